FILE: hdl/wpp_pkg.sv
// ============================================================================
// wpp_pkg
// Shared constants, register codes and configuration type of the wedge
// point projection unit.
// ============================================================================
package wpp_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int REG_W           = 20;
    localparam int DIR_W           = 16;
    localparam int OFFSET_W        = 19;
    localparam int TRIG_W          = 16;
    localparam int CFG_DATA_W      = 60;
    localparam int CFG_IDX_W       = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Z       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORIGIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_DIR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_HALF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COS_HALF      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVOLVE       = 3'd6;

    // reset values
    localparam logic signed [DIR_W-1:0] DIR_X_RST = 16'sd16384;
    localparam logic [TRIG_W-1:0]       SIN_RST   = 16'd1429;
    localparam logic [TRIG_W-1:0]       COS_RST   = 16'd32737;

    typedef struct packed {
        logic signed [REG_W-1:0] plane_z;
        logic signed [REG_W-1:0] ox;
        logic signed [REG_W-1:0] oy;
        logic signed [REG_W-1:0] oz;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
        logic [OFFSET_W-1:0]     offset;
        logic [TRIG_W-1:0]       sin_ha;
        logic [TRIG_W-1:0]       cos_ha;
        logic                    revolve;
    } t_cfg;

    // register contents after reset
    localparam t_cfg CFG_RST = '{
        plane_z: '0, ox: '0, oy: '0, oz: '0,
        dx: DIR_X_RST, dy: '0, dz: '0,
        offset: '0, sin_ha: SIN_RST, cos_ha: COS_RST, revolve: 1'b0
    };

    // width of a coordinate that holds both points and register values
    function automatic int wpp_cw(int w);
        return (w > REG_W) ? w : REG_W;
    endfunction

endpackage

FILE: hdl/wpp_point_if.sv
// ============================================================================
// wpp_point_if
// Valid/ready channel carrying one input mesh point.
// ============================================================================
interface wpp_point_if #(
    parameter int W = wpp_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

FILE: hdl/wpp_result_if.sv
// ============================================================================
// wpp_result_if
// Valid/ready channel carrying one moved point with its flags.
// ============================================================================
interface wpp_result_if #(
    parameter int W = wpp_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] moved_x;
    logic signed [W-1:0] moved_y;
    logic signed [W-1:0] moved_z;
    logic                on_plane;
    logic                saturated;

    modport source (output valid, moved_x, moved_y, moved_z, on_plane, saturated,
                    input ready);
    modport sink   (input valid, moved_x, moved_y, moved_z, on_plane, saturated,
                    output ready);
endinterface

FILE: hdl/wpp_front.sv
// ============================================================================
// wpp_front
// Seven stage geometry pipe: axis foot, radial vector and squared length.
// ============================================================================
module wpp_front #(
    parameter int W = wpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [W-1:0]           i_px,
    input  logic signed [W-1:0]           i_py,
    input  logic signed [W-1:0]           i_pz,
    input  wpp_pkg::t_cfg                 i_cfg,
    output logic                          o_vld,
    output logic [2*W+3:0]                o_rad,
    output logic [3*(wpp_pkg::wpp_cw(W)+10)+3*(W+2)+2*W+1:0] o_side
);
    import wpp_pkg::*;

    localparam int CW = wpp_cw(W);
    localparam int DW = CW + 1;
    localparam int PW = DW + DIR_W;
    localparam int TW = PW + 2;
    localparam int QW = TW - 13;
    localparam int MW = QW + DIR_W;
    localparam int AW = CW + 10;
    localparam int RW = W + 2;
    localparam int UW = W + 1;
    localparam int SQW = 2 * UW;
    localparam int NW = 2 * W + 4;

    localparam logic signed [TW-1:0] T_HALF = TW'(1) <<< 13;
    localparam logic signed [MW-1:0] M_HALF = MW'(1) <<< 13;
    localparam logic signed [AW:0]   LIM    = (AW+1)'((AW+1)'(1) <<< (W+1)) - 1;

    // stage valid bits
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    // point carried along
    logic signed [W-1:0] r1_px, r2_px, r3_px, r4_px, r5_px, r6_px, r7_px;
    logic signed [W-1:0] r1_py, r2_py, r3_py, r4_py, r5_py, r6_py, r7_py;
    logic r1_onp, r2_onp, r3_onp, r4_onp, r5_onp, r6_onp, r7_onp;
    logic r1_neg, r2_neg, r3_neg, r4_neg, r5_neg, r6_neg, r7_neg;
    // arithmetic
    logic signed [DW-1:0]  r1_d0, r1_d1, r1_d2;
    logic signed [PW-1:0]  r2_p0, r2_p1, r2_p2;
    logic signed [QW-1:0]  r3_tq;
    logic signed [MW-1:0]  r4_m0, r4_m1, r4_m2;
    logic signed [AW-1:0]  r5_a0, r5_a1, r5_a2, r6_a0, r6_a1, r6_a2, r7_a0, r7_a1, r7_a2;
    logic signed [RW-1:0]  r5_r0, r5_r1, r5_r2, r6_r0, r6_r1, r6_r2, r7_r0, r7_r1, r7_r2;
    logic [SQW-1:0]        r6_s0, r6_s1, r6_s2;
    logic [NW-1:0]         r7_n;

    logic signed [TW-1:0]  n_t;
    logic signed [TW-1:0]  n_tr;
    logic signed [MW-1:0]  n_am0, n_am1, n_am2;
    logic signed [AW-1:0]  n_a0, n_a1, n_a2;
    logic signed [AW:0]    n_f0, n_f1, n_f2;
    logic signed [RW-1:0]  n_r0, n_r1, n_r2;
    logic [UW-1:0]         n_u0, n_u1, n_u2;

    // dot product rounding
    always_comb begin
        n_t  = TW'(r2_p0) + TW'(r2_p1) + TW'(r2_p2);
        n_tr = (n_t + T_HALF) >>> 14;
    end

    // axis foot and clamped radial vector
    always_comb begin
        n_am0 = (r4_m0 + M_HALF) >>> 14;
        n_am1 = (r4_m1 + M_HALF) >>> 14;
        n_am2 = (r4_m2 + M_HALF) >>> 14;
        n_a0  = AW'(i_cfg.ox) + AW'(n_am0);
        n_a1  = AW'(i_cfg.oy) + AW'(n_am1);
        n_a2  = AW'(i_cfg.oz) + AW'(n_am2);
        n_f0  = (AW+1)'(r4_px) - (AW+1)'(n_a0);
        n_f1  = (AW+1)'(r4_py) - (AW+1)'(n_a1);
        n_f2  = (AW+1)'(i_cfg.plane_z) - (AW+1)'(n_a2);
        n_r0  = (n_f0 > LIM) ? RW'(LIM) : (n_f0 < -LIM) ? RW'(-LIM) : RW'(n_f0);
        n_r1  = (n_f1 > LIM) ? RW'(LIM) : (n_f1 < -LIM) ? RW'(-LIM) : RW'(n_f1);
        n_r2  = (n_f2 > LIM) ? RW'(LIM) : (n_f2 < -LIM) ? RW'(-LIM) : RW'(n_f2);
    end

    // magnitudes for squaring
    always_comb begin
        n_u0 = r5_r0[RW-1] ? UW'(-r5_r0) : UW'(r5_r0);
        n_u1 = r5_r1[RW-1] ? UW'(-r5_r1) : UW'(r5_r1);
        n_u2 = r5_r2[RW-1] ? UW'(-r5_r2) : UW'(r5_r2);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld} <= '0;
        end else if (i_en) begin
            {r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld} <=
                {i_vld, r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld};
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: offsets from axis origin
            r1_px  <= i_px;
            r1_py  <= i_py;
            r1_onp <= (CW'(i_pz) == CW'(i_cfg.plane_z));
            r1_neg <= (CW'(i_pz) < CW'(i_cfg.plane_z));
            r1_d0  <= DW'(i_px) - DW'(i_cfg.ox);
            r1_d1  <= DW'(i_py) - DW'(i_cfg.oy);
            r1_d2  <= DW'(i_cfg.plane_z) - DW'(i_cfg.oz);
            // stage 2: direction products
            r2_px  <= r1_px;  r2_py <= r1_py;  r2_onp <= r1_onp;  r2_neg <= r1_neg;
            r2_p0  <= PW'(r1_d0) * PW'(i_cfg.dx);
            r2_p1  <= PW'(r1_d1) * PW'(i_cfg.dy);
            r2_p2  <= PW'(r1_d2) * PW'(i_cfg.dz);
            // stage 3: projection length
            r3_px  <= r2_px;  r3_py <= r2_py;  r3_onp <= r2_onp;  r3_neg <= r2_neg;
            r3_tq  <= QW'(n_tr);
            // stage 4: scaled direction
            r4_px  <= r3_px;  r4_py <= r3_py;  r4_onp <= r3_onp;  r4_neg <= r3_neg;
            r4_m0  <= MW'(r3_tq) * MW'(i_cfg.dx);
            r4_m1  <= MW'(r3_tq) * MW'(i_cfg.dy);
            r4_m2  <= MW'(r3_tq) * MW'(i_cfg.dz);
            // stage 5: foot and radial vector
            r5_px  <= r4_px;  r5_py <= r4_py;  r5_onp <= r4_onp;  r5_neg <= r4_neg;
            r5_a0  <= n_a0;   r5_a1 <= n_a1;   r5_a2  <= n_a2;
            r5_r0  <= n_r0;   r5_r1 <= n_r1;   r5_r2  <= n_r2;
            // stage 6: squares
            r6_px  <= r5_px;  r6_py <= r5_py;  r6_onp <= r5_onp;  r6_neg <= r5_neg;
            r6_a0  <= r5_a0;  r6_a1 <= r5_a1;  r6_a2  <= r5_a2;
            r6_r0  <= r5_r0;  r6_r1 <= r5_r1;  r6_r2  <= r5_r2;
            r6_s0  <= SQW'(n_u0) * SQW'(n_u0);
            r6_s1  <= SQW'(n_u1) * SQW'(n_u1);
            r6_s2  <= SQW'(n_u2) * SQW'(n_u2);
            // stage 7: squared length
            r7_px  <= r6_px;  r7_py <= r6_py;  r7_onp <= r6_onp;  r7_neg <= r6_neg;
            r7_a0  <= r6_a0;  r7_a1 <= r6_a1;  r7_a2  <= r6_a2;
            r7_r0  <= r6_r0;  r7_r1 <= r6_r1;  r7_r2  <= r6_r2;
            r7_n   <= NW'(r6_s0) + NW'(r6_s1) + NW'(r6_s2);
        end
    end

    assign o_vld  = r7_vld;
    assign o_rad  = r7_n;
    assign o_side = {r7_a2, r7_a1, r7_a0, r7_r2, r7_r1, r7_r0, r7_py, r7_px, r7_onp, r7_neg};

endmodule

FILE: hdl/wpp_sqrt.sv
// ============================================================================
// wpp_sqrt
// Pipelined integer square root, one root bit per stage, floor result,
// with a sideband word carried alongside.
// ============================================================================
module wpp_sqrt #(
    parameter int M   = wpp_pkg::COORD_WIDTH_DEF + 2,
    parameter int SBW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [2*M-1:0]   i_rad,
    input  logic [SBW-1:0]   i_side,
    output logic             o_vld,
    output logic [M-1:0]     o_root,
    output logic [SBW-1:0]   o_side
);
    logic           r_vld  [M];
    logic [M:0]     r_rem  [M];
    logic [M-1:0]   r_root [M];
    logic [2*M-1:0] r_rad  [M];
    logic [SBW-1:0] r_sb   [M];

    for (genvar k = 0; k < M; k++) begin : g_stage
        logic           vld_in;
        logic [M:0]     rem_in;
        logic [M-1:0]   root_in;
        logic [2*M-1:0] rad_in;
        logic [SBW-1:0] sb_in;
        logic [M+2:0]   n_shift;
        logic [M+2:0]   n_trial;
        logic           n_take;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign sb_in   = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign sb_in   = r_sb[k-1];
        end

        // bring down two radicand bits and try the next root bit
        always_comb begin
            n_shift = {rem_in, rad_in[2*M-1 -: 2]};
            n_trial = (M+3)'({root_in, 2'b01});
            n_take  = (n_shift >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_take ? (M+1)'(n_shift - n_trial) : n_shift[M:0];
                r_root[k] <= {root_in[M-2:0], n_take};
                r_rad[k]  <= {rad_in[2*M-3:0], 2'b00};
                r_sb[k]   <= sb_in;
            end
        end
    end

    assign o_vld  = r_vld[M-1];
    assign o_root = r_root[M-1];
    assign o_side = r_sb[M-1];

endmodule

FILE: hdl/wpp_back.sv
// ============================================================================
// wpp_back
// Three stage back end: radius, wedge lift, revolve rotation, saturation
// and the output register.
// ============================================================================
module wpp_back #(
    parameter int W = wpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [W+1:0]         i_root,
    input  logic [3*(wpp_pkg::wpp_cw(W)+10)+3*(W+2)+2*W+1:0] i_side,
    input  wpp_pkg::t_cfg        i_cfg,
    output logic                 o_vld,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [W-1:0]  o_z,
    output logic                 o_onp,
    output logic                 o_sat
);
    import wpp_pkg::*;

    localparam int AW  = wpp_cw(W) + 10;
    localparam int RW  = W + 2;
    localparam int M   = W + 2;
    localparam int RDW = ((M > OFFSET_W) ? M : OFFSET_W) + 1;
    localparam int LPW = RDW + TRIG_W;
    localparam int RTW = RW + TRIG_W + 1;
    localparam int XW  = ((AW > LPW) ? AW : LPW) + 2;

    localparam logic signed [RTW-1:0] ROT_HALF = RTW'(1) <<< 14;
    localparam logic [LPW:0]          LFT_HALF = (LPW+1)'(1) << 14;
    localparam logic signed [XW-1:0]  OMAX     = (XW'(1) <<< (W-1)) - 1;
    localparam logic signed [XW-1:0]  OMIN     = -OMAX - 1;

    // sideband fields
    logic signed [AW-1:0] s_a0, s_a1, s_a2;
    logic signed [RW-1:0] s_r0, s_r1, s_r2;
    logic signed [W-1:0]  s_px, s_py;
    logic                 s_onp, s_neg;

    assign {s_a2, s_a1, s_a0, s_r2, s_r1, s_r0, s_py, s_px, s_onp, s_neg} = i_side;

    logic                  r1_vld, r2_vld, r3_vld;
    logic [RDW-1:0]        r1_radius;
    logic signed [RTW-1:0] r1_rot0, r1_rot1, r1_rot2;
    logic signed [AW-1:0]  r1_a0, r1_a1, r1_a2;
    logic signed [W-1:0]   r1_px, r1_py;
    logic                  r1_onp, r1_neg, r2_onp, r2_neg;
    logic [LPW-1:0]        r2_liftp;
    logic signed [XW-1:0]  r2_res0, r2_res1, r2_res2;
    logic signed [W-1:0]   r3_x, r3_y, r3_z;
    logic                  r3_onp, r3_sat;

    logic signed [RTW-1:0] n_rr0, n_rr1, n_rr2;
    logic signed [XW-1:0]  n_res0, n_res1, n_res2;
    logic [LPW:0]          n_lsum;
    logic signed [XW-1:0]  n_lift;
    logic signed [XW-1:0]  n_z;
    logic                  n_sx, n_sy, n_sz;

    // rotated radial vector or base point
    always_comb begin
        n_rr0 = (r1_rot0 + ROT_HALF) >>> 15;
        n_rr1 = (r1_rot1 + ROT_HALF) >>> 15;
        n_rr2 = (r1_rot2 + ROT_HALF) >>> 15;
        if (i_cfg.revolve) begin
            n_res0 = XW'(r1_a0) + XW'(n_rr0);
            n_res1 = XW'(r1_a1) + XW'(n_rr1);
            n_res2 = XW'(r1_a2) + XW'(n_rr2);
        end else begin
            n_res0 = XW'(r1_px);
            n_res1 = XW'(r1_py);
            n_res2 = XW'(i_cfg.plane_z);
        end
    end

    // signed lift on z and saturation checks
    always_comb begin
        n_lsum = {1'b0, r2_liftp} + LFT_HALF;
        n_lift = XW'(n_lsum >> 15);
        if (r2_onp) begin
            n_z = r2_res2;
        end else if (r2_neg) begin
            n_z = r2_res2 - n_lift;
        end else begin
            n_z = r2_res2 + n_lift;
        end
        n_sx = (r2_res0 > OMAX) || (r2_res0 < OMIN);
        n_sy = (r2_res1 > OMAX) || (r2_res1 < OMIN);
        n_sz = (n_z > OMAX) || (n_z < OMIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r1_vld, r2_vld, r3_vld} <= '0;
        end else if (i_en) begin
            {r1_vld, r2_vld, r3_vld} <= {i_vld, r1_vld, r2_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: radius and rotation products
            r1_radius <= RDW'(i_root) + RDW'(i_cfg.offset);
            r1_rot0   <= RTW'(s_r0) * RTW'(i_cfg.cos_ha);
            r1_rot1   <= RTW'(s_r1) * RTW'(i_cfg.cos_ha);
            r1_rot2   <= RTW'(s_r2) * RTW'(i_cfg.cos_ha);
            r1_a0     <= s_a0;  r1_a1 <= s_a1;  r1_a2 <= s_a2;
            r1_px     <= s_px;  r1_py <= s_py;
            r1_onp    <= s_onp; r1_neg <= s_neg;
            // stage 2: lift product and unlifted result
            r2_liftp  <= LPW'(r1_radius) * LPW'(i_cfg.sin_ha);
            r2_res0   <= n_res0; r2_res1 <= n_res1; r2_res2 <= n_res2;
            r2_onp    <= r1_onp; r2_neg <= r1_neg;
            // stage 3: output register
            r3_x      <= (r2_res0 > OMAX) ? W'(OMAX) : (r2_res0 < OMIN) ? W'(OMIN)
                                                                        : W'(r2_res0);
            r3_y      <= (r2_res1 > OMAX) ? W'(OMAX) : (r2_res1 < OMIN) ? W'(OMIN)
                                                                        : W'(r2_res1);
            r3_z      <= (n_z > OMAX) ? W'(OMAX) : (n_z < OMIN) ? W'(OMIN) : W'(n_z);
            r3_onp    <= r2_onp;
            r3_sat    <= n_sx || n_sy || n_sz;
        end
    end

    assign o_vld = r3_vld;
    assign o_x   = r3_x;
    assign o_y   = r3_y;
    assign o_z   = r3_z;
    assign o_onp = r3_onp;
    assign o_sat = r3_sat;

    // a held result stays while the pipe is frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r3_vld && !i_en) |=> r3_vld)
        else $error("result dropped during stall");

    // an item in stage 2 reaches the output register when the pipe moves
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_en && r2_vld) |=> r3_vld)
        else $error("item lost between last stages");

    // a bubble never turns into a result
    a_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_en && !r2_vld) |=> !r3_vld)
        else $error("result invented from a bubble");

endmodule

FILE: hdl/wedge_point_projection_unit.sv
// ============================================================================
// wedge_point_projection_unit
// Projects mesh points onto a wedge about an axis, streaming one point
// per cycle while the result channel is not stalled.
// ============================================================================
// Usage:
//   i_point carries one point (x, y, z, signed Q10.10) per transfer,
//   o_result returns the moved point with on_plane and saturated flags,
//   in the same order. Registers are written through i_cfg_we /
//   i_cfg_index / i_cfg_data while no point is in flight.
// Pipeline: 7 geometry stages, one square root stage per root bit and 3
//   back end stages lie between input transfer and result valid.
// Throughput: one point per cycle while o_result is not stalled; every
//   stage is a register stage fed by the one before it.
// Stall: when o_result is valid and not ready the whole pipe freezes and
//   i_point.ready drops; nothing is lost or repeated.
// Reset: pipe valid bits clear and all registers return to their reset
//   values (axis along x, wedge half angle 2.5 degrees, project mode).
// ============================================================================
module wedge_point_projection_unit #(
    parameter int COORD_WIDTH = wpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wpp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wpp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wpp_point_if.sink                        i_point,
    wpp_result_if.source                     o_result
);
    import wpp_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int AW  = wpp_cw(W) + 10;
    localparam int SBW = 3 * AW + 3 * (W + 2) + 2 * W + 2;
    localparam int M   = W + 2;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic en;

    logic             f_vld;
    logic [2*M-1:0]   f_rad;
    logic [SBW-1:0]   f_side;
    logic             q_vld;
    logic [M-1:0]     q_root;
    logic [SBW-1:0]   q_side;

    // register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PLANE_Z:       n_cfg.plane_z = i_cfg_data[REG_W-1:0];
                REG_AXIS_ORIGIN: begin
                    n_cfg.ox = i_cfg_data[REG_W-1:0];
                    n_cfg.oy = i_cfg_data[2*REG_W-1:REG_W];
                    n_cfg.oz = i_cfg_data[3*REG_W-1:2*REG_W];
                end
                REG_AXIS_DIR: begin
                    n_cfg.dx = i_cfg_data[DIR_W-1:0];
                    n_cfg.dy = i_cfg_data[2*DIR_W-1:DIR_W];
                    n_cfg.dz = i_cfg_data[3*DIR_W-1:2*DIR_W];
                end
                REG_RADIAL_OFFSET: n_cfg.offset  = i_cfg_data[OFFSET_W-1:0];
                REG_SIN_HALF:      n_cfg.sin_ha  = i_cfg_data[TRIG_W-1:0];
                REG_COS_HALF:      n_cfg.cos_ha  = i_cfg_data[TRIG_W-1:0];
                REG_REVOLVE:       n_cfg.revolve = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // global pipe advance
    assign en            = !o_result.valid || o_result.ready;
    assign i_point.ready = en;

    wpp_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_point.valid),
        .i_px    (i_point.point_x),
        .i_py    (i_point.point_y),
        .i_pz    (i_point.point_z),
        .i_cfg   (r_cfg),
        .o_vld   (f_vld),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    wpp_sqrt #(.M(M), .SBW(SBW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_vld   (q_vld),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    wpp_back #(.W(W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (q_vld),
        .i_root  (q_root),
        .i_side  (q_side),
        .i_cfg   (r_cfg),
        .o_vld   (o_result.valid),
        .o_x     (o_result.moved_x),
        .o_y     (o_result.moved_y),
        .o_z     (o_result.moved_z),
        .o_onp   (o_result.on_plane),
        .o_sat   (o_result.saturated)
    );

endmodule

FILE: test/wpp_projection_checker.sv
// ============================================================================
// wpp_projection_checker
// Watches the point and result channels of the wedge point projection unit,
// computes the moved point for every accepted input point and compares each
// returned result with the oldest pending prediction.
// ============================================================================
module wpp_projection_checker #(
    parameter int COORD_WIDTH = wpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wpp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wpp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wpp_point_if.sink                      i_point,
    wpp_result_if.sink                     i_result,
    output int                             o_fail_count,
    output int                             o_pending
);
    import wpp_pkg::*;

    typedef struct {
        longint mx;
        longint my;
        longint mz;
        bit     onp;
        bit     sat;
    } t_moved;

    t_cfg   cfg;
    t_moved moved_q[$];

    assign o_pending = moved_q.size();

    // round(v / 2^k), ties toward plus infinity
    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    // largest c with c*c <= n, n held as 128-bit unsigned
    function automatic longint isqrt(logic [127:0] n);
        logic [127:0] root;
        logic [127:0] c;
        root = '0;
        for (int k = 34; k >= 0; k--) begin
            c = root | (128'd1 << k);
            if (c * c <= n) root = c;
        end
        return longint'(root);
    endfunction

    function automatic t_moved project_point(longint px, longint py, longint pz);
        t_moved       res;
        longint       b[3], o[3], d[3], a[3], r[3], v[3];
        longint       t, tq, radius, lift, rlim, omax;
        logic [127:0] nsq;
        rlim = (longint'(1) <<< (COORD_WIDTH + 1)) - 1;
        omax = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        b[0] = px; b[1] = py; b[2] = cfg.plane_z;
        o[0] = cfg.ox; o[1] = cfg.oy; o[2] = cfg.oz;
        d[0] = cfg.dx; d[1] = cfg.dy; d[2] = cfg.dz;
        t = 0;
        for (int i = 0; i < 3; i++) t += d[i] * (b[i] - o[i]);
        tq = round_shift(t, 14);
        nsq = '0;
        for (int i = 0; i < 3; i++) begin
            a[i] = o[i] + round_shift(d[i] * tq, 14);
            r[i] = b[i] - a[i];
            if (r[i] > rlim) r[i] = rlim;
            if (r[i] < -rlim) r[i] = -rlim;
            nsq += 128'(r[i] < 0 ? -r[i] : r[i]) * 128'(r[i] < 0 ? -r[i] : r[i]);
        end
        radius = isqrt(nsq) + longint'(cfg.offset);
        lift = round_shift(longint'(cfg.sin_ha) * radius, 15);
        res.onp = (pz == longint'(cfg.plane_z));
        if (res.onp) lift = 0;
        else if (pz < longint'(cfg.plane_z)) lift = -lift;
        for (int i = 0; i < 3; i++)
            v[i] = cfg.revolve ? a[i] + round_shift(longint'(cfg.cos_ha) * r[i], 15) : b[i];
        v[2] += lift;
        res.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (v[i] > omax) begin v[i] = omax; res.sat = 1'b1; end
            if (v[i] < -omax - 1) begin v[i] = -omax - 1; res.sat = 1'b1; end
        end
        res.mx = v[0]; res.my = v[1]; res.mz = v[2];
        return res;
    endfunction

    // register shadow, input prediction and result comparison
    always @(posedge i_clk) begin
        t_moved want;
        int     errs;
        if (!i_rst_n) begin
            cfg <= CFG_RST;
            moved_q.delete();
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PLANE_Z:       cfg.plane_z <= i_cfg_data[19:0];
                    REG_AXIS_ORIGIN: begin
                        cfg.ox <= i_cfg_data[19:0];
                        cfg.oy <= i_cfg_data[39:20];
                        cfg.oz <= i_cfg_data[59:40];
                    end
                    REG_AXIS_DIR: begin
                        cfg.dx <= i_cfg_data[15:0];
                        cfg.dy <= i_cfg_data[31:16];
                        cfg.dz <= i_cfg_data[47:32];
                    end
                    REG_RADIAL_OFFSET: cfg.offset <= i_cfg_data[18:0];
                    REG_SIN_HALF:      cfg.sin_ha <= i_cfg_data[15:0];
                    REG_COS_HALF:      cfg.cos_ha <= i_cfg_data[15:0];
                    REG_REVOLVE:       cfg.revolve <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_point.valid && i_point.ready)
                moved_q.push_back(project_point(i_point.point_x, i_point.point_y,
                                                i_point.point_z));
            if (i_result.valid && i_result.ready) begin
                if (moved_q.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    errs++;
                end else begin
                    want = moved_q.pop_front();
                    if (longint'(i_result.moved_x) != want.mx) begin
                        $error("moved_x expected %0d actual %0d", want.mx, i_result.moved_x);
                        errs++;
                    end
                    if (longint'(i_result.moved_y) != want.my) begin
                        $error("moved_y expected %0d actual %0d", want.my, i_result.moved_y);
                        errs++;
                    end
                    if (longint'(i_result.moved_z) != want.mz) begin
                        $error("moved_z expected %0d actual %0d", want.mz, i_result.moved_z);
                        errs++;
                    end
                    if (i_result.on_plane !== want.onp) begin
                        $error("on_plane expected %0d actual %0d", want.onp,
                               i_result.on_plane);
                        errs++;
                    end
                    if (i_result.saturated !== want.sat) begin
                        $error("saturated expected %0d actual %0d", want.sat,
                               i_result.saturated);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

FILE: test/wedge_point_projection_unit_test.sv
// ============================================================================
// wedge_point_projection_unit_test
// Streams directed and random points through the wedge point projection
// unit under several register settings, with random gaps on both channels
// and long result stalls; the checker predicts and compares every result.
// ============================================================================
module wedge_point_projection_unit_test;
    import wpp_pkg::*;

    localparam int CW      = COORD_WIDTH_DEF;
    localparam int LATENCY = CW + 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count;
    int                    pending;
    bit                    hold_results = 1'b0;

    wpp_point_if  #(.W(CW)) point_ch ();
    wpp_result_if #(.W(CW)) result_ch ();

    wedge_point_projection_unit #(.COORD_WIDTH(CW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_point(point_ch.sink), .o_result(result_ch.source)
    );

    wpp_projection_checker #(.COORD_WIDTH(CW)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_point(point_ch.sink), .i_result(result_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        point_ch.valid = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        result_ch.ready = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ready side: random gaps, one long hold-off on request
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                result_ch.ready <= 1'b0;
                repeat (150) @(negedge i_clk);
                hold_results = 1'b0;
            end
            g = $urandom_range(0, 3) == 0 ? gap_len() : 0;
            if (g > 0) begin
                result_ch.ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one point and wait for its transfer, caller already at negedge
    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                              bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            point_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.point_x <= x;
        point_ch.point_y <= y;
        point_ch.point_z <= z;
        do @(posedge i_clk); while (!point_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        point_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // random coordinate: mostly moderate, sometimes extreme
    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return CW'($urandom());
            1: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            default: return 20'($signed($urandom_range(0, 60000)) - 30000);
        endcase
    endfunction

    function automatic logic [15:0] rnd_dir();
        return $urandom_range(0, 4) == 0 ? 16'($urandom()) :
               16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    initial begin
        logic [CW-1:0] pz_val;
        logic [CW-1:0] z;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, on plane, above and below, reset settings
        send_point('0, '0, '0, 1'b0);
        send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b0);
        send_point(20'h80000, 20'h80000, 20'h80000, 1'b0);
        send_point(20'h7FFFF, 20'h80000, 20'h00001, 1'b0);
        send_point(20'h00400, 20'h00800, 20'hFFC00, 1'b0);
        send_point(20'h12345, 20'hABCDE, '0, 1'b0);
        drain();
        // revolve with big factors, far-from-unit axis to hit the radial clamp
        write_reg(REG_REVOLVE, 60'd1);
        write_reg(REG_SIN_HALF, 60'hFFFF);
        write_reg(REG_COS_HALF, 60'hFFFF);
        write_reg(REG_RADIAL_OFFSET, 60'h7FFFF);
        write_reg(REG_AXIS_DIR, 60'({16'h8000, 16'h8000, 16'h8000}));
        write_reg(REG_AXIS_ORIGIN, {20'h7FFFF, 20'h80000, 20'h7FFFF});
        write_reg(REG_PLANE_Z, 60'h80000);
        write_reg(3'd7, 60'hFFFFFFFFFFFFFFF);
        @(negedge i_clk);
        send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b0);
        send_point(20'h80000, 20'h80000, 20'h80000, 1'b0);
        send_point(20'h7FFFF, 20'h80000, 20'h00000, 1'b0);
        drain();
        write_reg(REG_SIN_HALF, 60'd0);
        write_reg(REG_COS_HALF, 60'd32768);
        write_reg(REG_RADIAL_OFFSET, 60'd0);
        write_reg(REG_PLANE_Z, 60'h7FFFF);
        @(negedge i_clk);
        send_point(20'h00100, 20'hFFF00, 20'h7FFFF, 1'b0);
        send_point(20'h00100, 20'hFFF00, 20'h80000, 1'b0);
        drain();

        // random phases with fresh settings
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_PLANE_Z, 60'(rnd_coord()));
            write_reg(REG_AXIS_ORIGIN, {rnd_coord(), rnd_coord(), rnd_coord()});
            write_reg(REG_AXIS_DIR, ph < 3 ? 60'({16'd0, 16'd0, 16'd16384}) :
                                    60'({rnd_dir(), rnd_dir(), rnd_dir()}));
            write_reg(REG_RADIAL_OFFSET, ph == 8 ? 60'h7FFFF : 60'($urandom_range(0, 4096)));
            write_reg(REG_SIN_HALF, ph == 7 ? 60'hFFFF : 60'($urandom_range(0, 32768)));
            write_reg(REG_COS_HALF, ph == 6 ? 60'd0 : 60'($urandom_range(0, 32768)));
            write_reg(REG_REVOLVE, 60'(ph % 2));
            @(negedge i_clk);
            pz_val = u_checker.cfg.plane_z;
            if (ph == 2) hold_results = 1'b1;
            for (int n = 0; n < 148; n++) begin
                z = $urandom_range(0, 7) == 0 ? pz_val : rnd_coord();
                send_point(rnd_coord(), rnd_coord(), z, n % 40 > 5);
                if (ph == 4 && n == 70) begin
                    point_ch.valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: sim.f
hdl/wpp_pkg.sv
hdl/wpp_point_if.sv
hdl/wpp_result_if.sv
hdl/wpp_front.sv
hdl/wpp_sqrt.sv
hdl/wpp_back.sv
hdl/wedge_point_projection_unit.sv
test/wpp_projection_checker.sv
test/wedge_point_projection_unit_test.sv
